/* rtl/core/rcfe_pkg.sv */
package rcfe_pkg;

   // Frame layout
   localparam int FRAME_BYTES   = 26;
   localparam int PAYLOAD_BYTES = 22;
   localparam int CHANNELS      = 16;
   localparam int CH_WIDTH      = 11;
   localparam int PAYLOAD_BITS  = CHANNELS * CH_WIDTH;

   localparam logic [4:0] IDX_SYNC          = 5'd0;
   localparam logic [4:0] IDX_LENGTH        = 5'd1;
   localparam logic [4:0] IDX_TYPE          = 5'd2;
   localparam logic [4:0] IDX_PAYLOAD_FIRST = 5'd3;
   localparam logic [4:0] IDX_PAYLOAD_LAST  = 5'd24;
   localparam logic [4:0] IDX_CRC           = 5'd25;

   // Channel values
   localparam logic [10:0] CH_LOW    = 11'd172;
   localparam logic [10:0] CH_CENTRE = 11'd992;
   localparam logic [10:0] CH_HIGH   = 11'd1811;
   localparam logic [10:0] CH_SPAN   = 11'd1639;

   // Stick ends
   localparam logic signed [11:0] STICK_LO      = -12'sd1000;
   localparam logic signed [11:0] STICK_HI      = 12'sd1000;
   localparam logic signed [11:0] THROTTLE_LO   = 12'sd0;
   localparam logic signed [11:0] THROTTLE_HI   = 12'sd2000;
   localparam logic signed [12:0] STICK_OFFSET  = 13'sd1000;
   localparam logic [21:0]        ROUND_HALF    = 22'd1000;

   // floor(p / 2000) = floor((p >> 4) / 125) = ((p >> 4) * RECIP_125) >> RECIP_SHIFT
   localparam logic [18:0] RECIP_125   = 19'd268436;
   localparam int          RECIP_SHIFT = 25;

   localparam logic [7:0] CRC_POLY = 8'hD5;

   // Configuration registers
   typedef enum logic [1:0] {
      CSR_SYNC_BYTE   = 2'd0,
      CSR_LENGTH_BYTE = 2'd1,
      CSR_FRAME_TYPE  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   localparam logic [7:0] SYNC_RESET   = 8'd200;
   localparam logic [7:0] LENGTH_RESET = 8'd24;
   localparam logic [7:0] TYPE_RESET   = 8'd22;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] length_byte;
      logic [7:0] frame_type;
   } cfg_type;

   typedef struct packed {
      logic signed [11:0] roll;
      logic signed [11:0] pitch;
      logic signed [11:0] throttle;
      logic signed [11:0] yaw;
      logic               arm_request;
      logic               failsafe;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [4:0] byte_index;
      logic       last;
   } rsp_type;

endpackage

/* rtl/core/rc_channel_frame_encoder.sv */
// RC-channels frame encoder. Each sample taken with start (while busy is low) becomes one
// 26-byte frame: sync, length, type, 16 packed 11-bit channels in 22 bytes, CRC-8 (poly 0xD5).
// The frame leaves one beat per cycle on rsp_data under rsp_valid, without gaps, with last
// on the CRC beat; the receiver cannot stall, so every beat must be taken as shown. The first
// beat passes the sample, product, channel, serializer and output registers. The byte
// serializer sets the sustained rate, taking a payload only when idle or on the CRC beat; up
// to three more samples wait in the mapping pipeline, and busy rises when all of it is full.
// csr_ready is always high; write configuration only while no frame is pending or in flight.
module rc_channel_frame_encoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rcfe_pkg::req_type    req_sample,
   output logic                 rsp_valid,
   output rcfe_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_data
);
   import rcfe_pkg::*;

   cfg_type                 cfg;
   logic                    req_ready;
   logic                    chan_valid;
   logic                    chan_ready;
   logic [PAYLOAD_BITS-1:0] chan_payload;

   rcfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rcfe_mapper u_mapper (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start),
      .in_ready    (req_ready),
      .in_sample   (req_sample),
      .out_valid   (chan_valid),
      .out_ready   (chan_ready),
      .out_payload (chan_payload)
   );

   rcfe_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (chan_valid),
      .in_ready   (chan_ready),
      .in_payload (chan_payload),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign busy = !req_ready;

endmodule

/* rtl/core/rcfe_csr.sv */
module rcfe_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_data,
   output rcfe_pkg::cfg_type     cfg
);
   import rcfe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_BYTE:   cfg_in.sync_byte   = csr_data;
            CSR_LENGTH_BYTE: cfg_in.length_byte = csr_data;
            CSR_FRAME_TYPE:  cfg_in.frame_type  = csr_data;
            CSR_UNUSED:      cfg_in = cfg_ff;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte   <= SYNC_RESET;
         cfg_ff.length_byte <= LENGTH_RESET;
         cfg_ff.frame_type  <= TYPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

/* rtl/core/rcfe_mapper.sv */
module rcfe_mapper (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rcfe_pkg::req_type      in_sample,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [rcfe_pkg::PAYLOAD_BITS-1:0] out_payload
);
   import rcfe_pkg::*;

   typedef struct packed {
      logic        lo_sat;
      logic        hi_sat;
      logic [17:0] scaled;
   } stick_prod_type;

   // First half: offset sticks, multiply by span, add rounding half, drop 4 bits
   function automatic stick_prod_type map_front(logic signed [11:0] v, logic thr);
      logic signed [12:0] d;
      logic [21:0]        p;
      stick_prod_type     r;
      d = thr ? {v[11], v} : ({v[11], v} + STICK_OFFSET);
      p = {11'b0, d[10:0]} * {11'b0, CH_SPAN} + ROUND_HALF;
      r.lo_sat = thr ? (v <= THROTTLE_LO) : (v <= STICK_LO);
      r.hi_sat = thr ? (v >= THROTTLE_HI) : (v >= STICK_HI);
      r.scaled = p[21:4];
      return r;
   endfunction

   // Second half: divide by 125 through the reciprocal, add CH_LOW, then saturate
   function automatic logic [10:0] map_back(stick_prod_type sp);
      logic [36:0] prod;
      logic [10:0] q;
      prod = {19'b0, sp.scaled} * {18'b0, RECIP_125};
      q    = prod[RECIP_SHIFT+10:RECIP_SHIFT];
      if (sp.lo_sat)
         return CH_LOW;
      else if (sp.hi_sat)
         return CH_HIGH;
      else
         return CH_LOW + q;
   endfunction

   // Sample register
   logic    smp_valid_ff;
   req_type smp_ff;

   // Product register
   logic           prod_valid_ff;
   stick_prod_type roll_ff, pitch_ff, thr_ff, yaw_ff;
   logic           arm_ff, fs_ff;

   // Channel register
   logic                    chan_valid_ff;
   logic [PAYLOAD_BITS-1:0] chan_ff;
   logic [PAYLOAD_BITS-1:0] chan_in;

   logic chan_ready, prod_ready;

   assign chan_ready = !chan_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || chan_ready;
   assign in_ready   = !smp_valid_ff || prod_ready;

   always_comb begin
      chan_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         chan_in[i*CH_WIDTH +: CH_WIDTH] = CH_CENTRE;
      end
      if (fs_ff) begin
         chan_in[2*CH_WIDTH +: CH_WIDTH] = CH_LOW;
         chan_in[4*CH_WIDTH +: CH_WIDTH] = CH_LOW;
      end else begin
         chan_in[0*CH_WIDTH +: CH_WIDTH] = map_back(roll_ff);
         chan_in[1*CH_WIDTH +: CH_WIDTH] = map_back(pitch_ff);
         chan_in[2*CH_WIDTH +: CH_WIDTH] = map_back(thr_ff);
         chan_in[3*CH_WIDTH +: CH_WIDTH] = map_back(yaw_ff);
         chan_in[4*CH_WIDTH +: CH_WIDTH] = arm_ff ? CH_HIGH : CH_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         chan_valid_ff <= 1'b0;
      end else begin
         if (in_ready)
            smp_valid_ff <= in_valid;
         if (prod_ready)
            prod_valid_ff <= smp_valid_ff;
         if (chan_ready)
            chan_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid)
         smp_ff <= in_sample;
      if (prod_ready && smp_valid_ff) begin
         roll_ff  <= map_front(smp_ff.roll, 1'b0);
         pitch_ff <= map_front(smp_ff.pitch, 1'b0);
         thr_ff   <= map_front(smp_ff.throttle, 1'b1);
         yaw_ff   <= map_front(smp_ff.yaw, 1'b0);
         arm_ff   <= smp_ff.arm_request;
         fs_ff    <= smp_ff.failsafe;
      end
      if (chan_ready && prod_valid_ff)
         chan_ff <= chan_in;
   end

   assign out_valid   = chan_valid_ff;
   assign out_payload = chan_ff;

endmodule

/* rtl/core/rcfe_serializer.sv */
module rcfe_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  rcfe_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [rcfe_pkg::PAYLOAD_BITS-1:0] in_payload,
   output logic                   rsp_valid,
   output rcfe_pkg::rsp_type      rsp_data
);
   import rcfe_pkg::*;

   function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   logic                    active_ff, active_in;
   logic [4:0]              idx_ff, idx_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [7:0]              crc_ff, crc_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic       frame_end;
   logic       load;
   logic [7:0] cur_byte;

   assign frame_end = active_ff && (idx_ff == IDX_CRC);
   assign in_ready  = !active_ff || frame_end;
   assign load      = in_ready && in_valid;

   always_comb begin
      priority if (idx_ff == IDX_SYNC)
         cur_byte = cfg.sync_byte;
      else if (idx_ff == IDX_LENGTH)
         cur_byte = cfg.length_byte;
      else if (idx_ff == IDX_TYPE)
         cur_byte = cfg.frame_type;
      else if (idx_ff == IDX_CRC)
         cur_byte = crc_ff;
      else
         cur_byte = payload_ff[7:0];
   end

   always_comb begin
      active_in  = active_ff;
      idx_in     = idx_ff;
      payload_in = payload_ff;
      crc_in     = crc_ff;
      if (active_ff) begin
         idx_in = idx_ff + 5'd1;
         if (idx_ff >= IDX_PAYLOAD_FIRST && idx_ff <= IDX_PAYLOAD_LAST)
            payload_in = {8'b0, payload_ff[PAYLOAD_BITS-1:8]};
         if (idx_ff >= IDX_TYPE && idx_ff <= IDX_PAYLOAD_LAST)
            crc_in = crc8_step(crc_ff, cur_byte);
         if (frame_end)
            active_in = 1'b0;
      end
      // Next frame starts right behind the CRC beat
      if (load) begin
         active_in  = 1'b1;
         idx_in     = IDX_SYNC;
         payload_in = in_payload;
         crc_in     = '0;
      end
   end

   always_comb begin
      rsp_in.frame_byte = cur_byte;
      rsp_in.byte_index = idx_ff;
      rsp_in.last       = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= IDX_SYNC;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      crc_ff     <= crc_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/rcfe_checker.sv */
module rcfe_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input rcfe_pkg::rsp_type rsp_data
);
   import rcfe_pkg::*;

   // A frame goes out without gaps
   a_frame_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("frame beat missing before last");

   // Indexes count up by one within a frame
   a_index_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=>
         rsp_data.byte_index == $past(rsp_data.byte_index) + 5'd1)
      else $error("byte_index did not advance");

   // Last marks exactly the CRC beat
   a_last_on_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.byte_index == IDX_CRC)))
      else $error("last does not match CRC position");

   // A new burst opens on the sync beat
   a_frame_opens: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_data.byte_index == IDX_SYNC)
      else $error("frame did not start at byte 0");

endmodule

bind rc_channel_frame_encoder rcfe_checker u_rcfe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* verif/tb_top.sv */
module tb_top;
   import rcfe_pkg::*;

   // Expected frames, built beat by beat from each sample that the block takes.
   class rc_frame_board;
      cfg_type regs;
      rsp_type expected_bytes[$];
      int      errors;

      function new();
         regs.sync_byte   = SYNC_RESET;
         regs.length_byte = LENGTH_RESET;
         regs.frame_type  = TYPE_RESET;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_SYNC_BYTE:   regs.sync_byte   = value;
            CSR_LENGTH_BYTE: regs.length_byte = value;
            CSR_FRAME_TYPE:  regs.frame_type  = value;
            default: ;
         endcase
      endfunction

      function logic [10:0] stick_to_channel(int v, int lo, int hi);
         if (v <= lo) return CH_LOW;
         if (v >= hi) return CH_HIGH;
         return 11'(172 + ((v - lo) * 1639 + (hi - lo) / 2) / (hi - lo));
      endfunction

      function void take_sample(req_type s);
         logic [10:0]  ch[CHANNELS];
         logic [175:0] packed_bits;
         logic [7:0]   frame[FRAME_BYTES];
         logic [7:0]   crc;
         rsp_type      beat;
         if (s.failsafe) begin
            ch[0] = CH_CENTRE;
            ch[1] = CH_CENTRE;
            ch[2] = CH_LOW;
            ch[3] = CH_CENTRE;
            ch[4] = CH_LOW;
         end else begin
            ch[0] = stick_to_channel(int'($signed(s.roll)), -1000, 1000);
            ch[1] = stick_to_channel(int'($signed(s.pitch)), -1000, 1000);
            ch[2] = stick_to_channel(int'($signed(s.throttle)), 0, 2000);
            ch[3] = stick_to_channel(int'($signed(s.yaw)), -1000, 1000);
            ch[4] = s.arm_request ? CH_HIGH : CH_LOW;
         end
         for (int i = 5; i < CHANNELS; i++) ch[i] = CH_CENTRE;
         // channel 0 lands in the low bits of the first payload byte
         for (int i = 0; i < CHANNELS; i++) packed_bits[i*11 +: 11] = ch[i];
         frame[0] = regs.sync_byte;
         frame[1] = regs.length_byte;
         frame[2] = regs.frame_type;
         for (int k = 0; k < PAYLOAD_BYTES; k++) frame[3 + k] = packed_bits[k*8 +: 8];
         crc = 8'h00;
         for (int k = 2; k < FRAME_BYTES - 1; k++) begin
            crc = crc ^ frame[k];
            for (int b = 0; b < 8; b++) begin
               crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
            end
         end
         frame[FRAME_BYTES - 1] = crc;
         for (int k = 0; k < FRAME_BYTES; k++) begin
            beat.frame_byte = frame[k];
            beat.byte_index = 5'(k);
            beat.last       = (k == FRAME_BYTES - 1);
            expected_bytes.push_back(beat);
         end
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected beat: frame_byte=%0h byte_index=%0d last=%0b",
                   got.frame_byte, got.byte_index, got.last);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
            errors++;
         end
         if (got.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_sample;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   rc_frame_board frames = new();

   rc_channel_frame_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) frames.check_byte(rsp_data);
   end

   function automatic req_type mk_sample(int r, int p, int t, int y, bit arm, bit fs);
      req_type s;
      s.roll        = r[11:0];
      s.pitch       = p[11:0];
      s.throttle    = t[11:0];
      s.yaw         = y[11:0];
      s.arm_request = arm;
      s.failsafe    = fs;
      return s;
   endfunction

   // Mostly nominal travel, some full-range noise, some hits right at the ends.
   function automatic int rand_stick(int lo, int hi);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 5) return lo + int'($urandom_range(0, hi - lo));
      if (sel <= 7) return int'($urandom_range(0, 4095)) - 2048;
      if (sel == 8) return ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 4)) - 2;
      return $urandom_range(0, 1) ? -2048 : 2047;
   endfunction

   function automatic req_type rand_sample();
      return mk_sample(rand_stick(-1000, 1000), rand_stick(-1000, 1000),
                       rand_stick(0, 2000), rand_stick(-1000, 1000),
                       1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
   endfunction

   // Leave start high on return so back-to-back samples keep it asserted.
   task automatic drive_sample(req_type s);
      req_sample <= s;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      frames.take_sample(s);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 99) < 13) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      frames.set_reg(idx, value);
   endtask

   // Hold off until every queued byte has come out, then let the pipeline settle.
   task automatic drain();
      start <= 1'b0;
      while (frames.expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      logic [7:0] setting[5][3];
      setting[0] = '{8'h00, 8'h00, 8'h00};
      setting[1] = '{8'hFF, 8'hFF, 8'hFF};
      setting[2] = '{8'($urandom), 8'($urandom), 8'($urandom)};
      setting[3] = '{8'hEE, 8'h18, 8'h16};
      setting[4] = '{8'($urandom), 8'($urandom), 8'($urandom)};

      reset      <= 1'b1;
      start      <= 1'b0;
      req_sample <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_SYNC_BYTE;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: centers, ends, saturation, rounding, failsafe overriding sticks and arm
      drive_sample(mk_sample(0, 0, 1000, 0, 0, 0));
      drive_sample(mk_sample(-1000, -1000, 0, -1000, 0, 0));
      drive_sample(mk_sample(1000, 1000, 2000, 1000, 1, 0));
      drive_sample(mk_sample(-1001, 1001, -1, 2001, 0, 0));
      drive_sample(mk_sample(-2048, 2047, -2048, 2047, 1, 0));
      drive_sample(mk_sample(2047, -2048, 2047, -2048, 0, 0));
      drive_sample(mk_sample(-999, 999, 1, 1999, 1, 0));
      drive_sample(mk_sample(1, -1, 999, 1001, 0, 0));
      drive_sample(mk_sample(-500, 500, 1001, -3, 1, 0));
      drive_sample(mk_sample(-1366, 1365, -1366, 1365, 0, 0));
      drive_sample(mk_sample(2047, -2048, 2047, -2048, 1, 1));
      drive_sample(mk_sample(0, 0, 0, 0, 0, 1));
      drive_sample(mk_sample(-1000, 1000, 2000, 1000, 1, 1));
      drive_sample(mk_sample(-1, -1, -1, -1, 1, 0));
      maybe_idle();
      drive_sample(mk_sample(333, -333, 667, 7, 0, 0));

      for (int ph = 0; ph < 5; ph++) begin
         drain();
         write_csr(CSR_SYNC_BYTE, setting[ph][0]);
         write_csr(CSR_LENGTH_BYTE, setting[ph][1]);
         write_csr(CSR_UNUSED, 8'($urandom));
         write_csr(CSR_FRAME_TYPE, setting[ph][2]);
         csr_valid <= 1'b0;
         @(posedge clock);
         for (int k = 0; k < 63; k++) begin
            drive_sample(rand_sample());
            // one phase runs back to back with no gaps
            if (ph != 2) maybe_idle();
         end
      end

      drain();
      if (frames.errors == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
